FILE: rtl/afc_pkg.sv
package afc_pkg;

  // Sample format codes; code three behaves as float
  localparam logic [1:0] FMT_INT16 = 2'd0;
  localparam logic [1:0] FMT_INT24 = 2'd1;
  localparam logic [1:0] FMT_FLT32 = 2'd2;
  localparam logic [1:0] FMT_ALT32 = 2'd3;

  // Result source selected at the output
  localparam logic [1:0] SEL_DIRECT = 2'd0;
  localparam logic [1:0] SEL_I2F    = 2'd1;
  localparam logic [1:0] SEL_F2I    = 2'd2;

  // Scale significands: 32767.5 = 0xFFFF00 * 2^-9, 8388607.5 = 0xFFFFFF * 2^-1
  localparam logic [23:0] SCALE16_SIG = 24'hFFFF00;
  localparam logic [23:0] SCALE24_SIG = 24'hFFFFFF;

  localparam logic [31:0] MAX16 = 32'h0000_7FFF;
  localparam logic [31:0] MIN16 = 32'hFFFF_8000;
  localparam logic [31:0] MAX24 = 32'h007F_FFFF;
  localparam logic [31:0] MIN24 = 32'hFF80_0000;

  // Leading zero count of a nonzero 24-bit word
  function automatic logic [4:0] clz24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) begin
        n = 5'(23 - i);
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/afc_i2f.sv
module afc_i2f (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] sample,
  input  logic        is24,
  output logic [31:0] result
);

  // Stage 1: odd numerator n = 2v+1, keep sign and magnitude
  logic signed [24:0] val;
  logic signed [25:0] num;
  logic [25:0]        num_mag;
  logic [23:0]        mag1;
  logic               neg1;
  logic               wide1;

  always_comb begin
    val = is24 ? 25'($signed(sample[23:0])) : 25'($signed(sample[15:0]));
    num = 26'(val) * 26'sd2 + 26'sd1;
    num_mag = num[25] ? 26'(-num) : 26'(num);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1  <= num_mag[23:0];
      neg1  <= num[25];
      wide1 <= is24;
    end
  end

  // Stage 2: n/(2^k-1) repeats n every k bits; normalise the repeated stream
  logic [71:0] stream;
  logic [4:0]  lz;
  logic [71:0] shifted;
  logic [24:0] win2;
  logic [7:0]  exp2;
  logic        neg2;

  always_comb begin
    if (wide1) begin
      stream = {mag1, mag1, mag1};
      lz     = afc_pkg::clz24(mag1);
    end else begin
      stream = {mag1[15:0], mag1[15:0], mag1[15:0], 24'd0};
      lz     = afc_pkg::clz24({mag1[15:0], 8'hFF});
    end
    shifted = stream << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      win2 <= shifted[71:47];
      exp2 <= 8'd126 - {3'd0, lz};
      neg2 <= neg1;
    end
  end

  // Stage 3: round on the guard bit; the stream never ends so no tie arises
  logic [24:0] rnd;

  always_comb begin
    rnd = {1'b0, win2[24:1]} + {24'd0, win2[0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rnd[24]) begin
        result <= {neg2, exp2 + 8'd1, 23'd0};
      end else begin
        result <= {neg2, exp2, rnd[22:0]};
      end
    end
  end

endmodule

FILE: rtl/afc_f2i.sv
module afc_f2i (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] sample,
  input  logic        is24,
  output logic [31:0] result,
  output logic        clip
);

  // Stage 1: unpack and multiply significand by the scale
  logic [47:0] prod1;
  logic        sgn1;
  logic [7:0]  ex1;
  logic        nan1;
  logic        inf1;
  logic        den1;
  logic        wide1;

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= {24'd0, 1'b1, sample[22:0]} *
               {24'd0, (is24 ? afc_pkg::SCALE24_SIG : afc_pkg::SCALE16_SIG)};
      sgn1  <= sample[31];
      ex1   <= sample[30:23];
      nan1  <= (sample[30:23] == 8'hFF) && (sample[22:0] != 23'd0);
      inf1  <= (sample[30:23] == 8'hFF) && (sample[22:0] == 23'd0);
      den1  <= sample[22:0] != 23'd0;
      wide1 <= is24;
    end
  end

  // Stage 2: take 24 significant bits and round to nearest even
  logic [23:0]       sig;
  logic              grd;
  logic              stk;
  logic signed [9:0] ebase;
  logic signed [9:0] e2n;
  logic [24:0]       s25;
  logic [23:0]       sig2;
  logic signed [9:0] e2;
  logic              sgn2;
  logic [7:0]        ex2;
  logic              nan2;
  logic              inf2;
  logic              den2;
  logic              wide2;

  always_comb begin
    ebase = $signed({2'b00, ex1}) - (wide1 ? 10'sd127 : 10'sd135);
    if (prod1[47]) begin
      sig = prod1[47:24];
      grd = prod1[23];
      stk = |prod1[22:0];
      e2n = ebase;
    end else begin
      sig = prod1[46:23];
      grd = prod1[22];
      stk = |prod1[21:0];
      e2n = ebase - 10'sd1;
    end
    s25 = {1'b0, sig} + {24'd0, grd & (stk | sig[0])};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sig2  <= s25[24] ? 24'h800000 : s25[23:0];
      e2    <= s25[24] ? e2n + 10'sd1 : e2n;
      sgn2  <= sgn1;
      ex2   <= ex1;
      nan2  <= nan1;
      inf2  <= inf1;
      den2  <= den1;
      wide2 <= wide1;
    end
  end

  // Stage 3: floor, saturate and sign
  logic signed [9:0] top;
  logic signed [9:0] lbit;
  logic [9:0]        sh;
  logic [23:0]       ipart;
  logic              frac;
  logic [31:0]       mag;
  logic [31:0]       vmax;
  logic [31:0]       vmin;
  logic [31:0]       res_n;
  logic              clip_n;

  always_comb begin
    top   = e2 + 10'sd23;
    lbit  = wide2 ? 10'sd23 : 10'sd15;
    vmax  = wide2 ? afc_pkg::MAX24 : afc_pkg::MAX16;
    vmin  = wide2 ? afc_pkg::MIN24 : afc_pkg::MIN16;
    sh    = 10'(-e2);
    ipart = 24'd0;
    frac  = 1'b1;
    if (sh < 10'd24) begin
      ipart = sig2 >> sh[4:0];
      frac  = |(sig2 & ~(24'hFFFFFF << sh[4:0]));
    end
    mag    = {8'd0, ipart} + {31'd0, sgn2 & frac};
    res_n  = sgn2 ? 32'(-mag) : mag;
    clip_n = 1'b0;
    if (nan2) begin
      res_n  = 32'd0;
      clip_n = 1'b1;
    end else if (inf2) begin
      res_n  = sgn2 ? vmin : vmax;
      clip_n = 1'b1;
    end else if (ex2 == 8'd0) begin
      res_n = (sgn2 && den2) ? 32'hFFFF_FFFF : 32'd0;
    end else if (!sgn2 && (top >= lbit)) begin
      res_n  = vmax;
      clip_n = 1'b1;
    end else if (sgn2 && (top > lbit)) begin
      res_n  = vmin;
      clip_n = 1'b1;
    end else if (sgn2 && (top == lbit)) begin
      res_n  = vmin;
      clip_n = sig2 != 24'h800000;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_n;
      clip   <= clip_n;
    end
  end

endmodule

FILE: rtl/audio_sample_format_converter.sv
// Throughput: one sample per cycle; the three stages advance together and
// hold while a finished result is stalled at the output.
// Reset: synchronous, active high; clears the stage valid bits and sets the
// formats to int16 in, float32 out.
module audio_sample_format_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [31:0] sample_word,
  input  logic        last_in,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] result_word,
  output logic        clipped,
  output logic        last_out
);

  // Configuration registers
  logic [1:0] source_format;
  logic [1:0] dest_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= afc_pkg::FMT_INT16;
      dest_format   <= afc_pkg::FMT_FLT32;
    end else if (cfg_write) begin
      if (cfg_index) begin
        dest_format <= cfg_data;
      end else begin
        source_format <= cfg_data;
      end
    end
  end

  // Pipeline control: hold every stage while the output beat is stalled
  logic en;
  logic v1, v2, v3;

  assign en           = !(v3 && result_stall);
  assign sample_stall = v3 && result_stall;
  assign result_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= sample_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Decode the conversion and form the direct results
  logic [1:0]  src;
  logic [1:0]  dst;
  logic [1:0]  sel0;
  logic [31:0] direct0;
  logic        is24;

  always_comb begin
    src = (source_format == afc_pkg::FMT_ALT32) ? afc_pkg::FMT_FLT32 : source_format;
    dst = (dest_format == afc_pkg::FMT_ALT32) ? afc_pkg::FMT_FLT32 : dest_format;
    sel0    = afc_pkg::SEL_DIRECT;
    direct0 = sample_word;
    is24    = 1'b0;
    case (src)
      afc_pkg::FMT_INT16: begin
        case (dst)
          afc_pkg::FMT_INT16: direct0 = 32'($signed(sample_word[15:0]));
          afc_pkg::FMT_INT24: direct0 = {{8{sample_word[15]}}, sample_word[15:0], 8'd0};
          default:            sel0    = afc_pkg::SEL_I2F;
        endcase
      end
      afc_pkg::FMT_INT24: begin
        is24 = 1'b1;
        case (dst)
          afc_pkg::FMT_INT16: direct0 = 32'($signed(sample_word[23:8]));
          afc_pkg::FMT_INT24: direct0 = 32'($signed(sample_word[23:0]));
          default:            sel0    = afc_pkg::SEL_I2F;
        endcase
      end
      default: begin
        case (dst)
          afc_pkg::FMT_INT16: sel0 = afc_pkg::SEL_F2I;
          afc_pkg::FMT_INT24: begin
            sel0 = afc_pkg::SEL_F2I;
            is24 = 1'b1;
          end
          default: direct0 = sample_word;
        endcase
      end
    endcase
  end

  // Carry selection, direct value and end marker alongside the datapath
  logic [1:0]  sel1, sel2, sel3;
  logic [31:0] dir1, dir2, dir3;
  logic        last1, last2, last3;

  always_ff @(posedge clk) begin
    if (en) begin
      sel1  <= sel0;
      sel2  <= sel1;
      sel3  <= sel2;
      dir1  <= direct0;
      dir2  <= dir1;
      dir3  <= dir2;
      last1 <= last_in;
      last2 <= last1;
      last3 <= last2;
    end
  end

  logic [31:0] i2f_res;
  logic [31:0] f2i_res;
  logic        f2i_clip;

  afc_i2f u_i2f (
    .clk    (clk),
    .en     (en),
    .sample (sample_word),
    .is24   (is24),
    .result (i2f_res)
  );

  afc_f2i u_f2i (
    .clk    (clk),
    .en     (en),
    .sample (sample_word),
    .is24   (is24),
    .result (f2i_res),
    .clip   (f2i_clip)
  );

  // Select the result beat
  always_comb begin
    case (sel3)
      afc_pkg::SEL_I2F: begin
        result_word = i2f_res;
        clipped     = 1'b0;
      end
      afc_pkg::SEL_F2I: begin
        result_word = f2i_res;
        clipped     = f2i_clip;
      end
      default: begin
        result_word = dir3;
        clipped     = 1'b0;
      end
    endcase
  end

  assign last_out = last3;

  a_clip_f2i: assert property (@(posedge clk) disable iff (rst)
    (result_valid && clipped) |-> (sel3 == afc_pkg::SEL_F2I))
    else $error("clip flag on a path that cannot saturate");

  a_i2f_normal: assert property (@(posedge clk) disable iff (rst)
    (result_valid && sel3 == afc_pkg::SEL_I2F) |-> (result_word[30:23] != 8'd0))
    else $error("integer to float result not normal");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(last_out)))
    else $error("stalled stage lost its beat");

endmodule
